[design/u2u_pkg.sv]
// shared types, constants and helpers for the utf-8 to ucs4 decoder
// no dependencies
package u2u_pkg;

	// width of the per-buffer written counter
	localparam int COUNT_WIDTH = 16;
	localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

	localparam int CP_W   = 21;
	localparam int CNT_W  = 16;
	localparam int CAP_W  = 16;
	localparam int CFG_IDX_W = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRING_MODE  = 1'b1;

	// lead byte boundaries and masks
	localparam logic [7:0] B_CONT_LO = 8'h80;
	localparam logic [7:0] B_LEAD2   = 8'hC2;
	localparam logic [7:0] B_LEAD3   = 8'hE0;
	localparam logic [7:0] B_LEAD4   = 8'hF0;
	localparam logic [7:0] B_BAD_HI  = 8'hF8;
	localparam logic [7:0] M_LEAD2   = 8'h1F;
	localparam logic [7:0] M_CONT    = 8'h3F;
	localparam logic [7:0] M_LEAD3   = 8'h0F;
	localparam logic [7:0] M_LEAD4   = 8'h07;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_LEAD = 2'd1,
		ST_TRUNC    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef struct packed {
		logic [CAP_W-1:0] out_capacity;
		logic             string_mode;
	} cfg_t;

	// results caused by one byte: code point, terminator, end
	typedef struct packed {
		logic [CP_W-1:0]  cp;
		logic [CNT_W-1:0] cp_cnt;
		status_t          fin_st;
		logic [CNT_W-1:0] fin_cnt;
		logic [2:0]       mask;    // [0] code point, [1] terminator, [2] end
	} grp_t;

	localparam int GRP_CP   = 0;
	localparam int GRP_TERM = 1;
	localparam int GRP_END  = 2;

	// low bits of the counter as seen on the output port
	function automatic logic [CNT_W-1:0] cnt_port(input count_t c);
		logic [31:0] w;
		w = 32'(c);
		return w[CNT_W-1:0];
	endfunction

endpackage

[design/u2u_decode.sv]
// per-byte decode logic and buffer state of the utf-8 decoder
// uses u2u_pkg
module u2u_decode import u2u_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] byte_in,
	input  logic       last_in,
	input  cfg_t       cfg,
	output grp_t       grp
);

	logic [CP_W-1:0] acc_q;
	logic [1:0]      pend_q;
	count_t          written_q;
	logic            stopped_q;
	status_t         stop_st_q;

	logic [CP_W-1:0] acc_n;
	logic [1:0]      pend_n;
	count_t          written_n;
	logic            stopped_n;
	status_t         stop_st_n;
	logic [31:0]     lim;
	count_t          fin_cnt;

	// output limit from capacity and string mode
	always_comb begin
		lim = (cfg.out_capacity == '0) ? COUNT_MAX : 32'(cfg.out_capacity);
		if (lim > COUNT_MAX) begin
			lim = COUNT_MAX;
		end
		if (cfg.string_mode && lim != '0) begin
			lim = lim - 32'd1;
		end
	end

	always_comb begin
		acc_n     = acc_q;
		pend_n    = pend_q;
		written_n = written_q;
		stopped_n = stopped_q;
		stop_st_n = stop_st_q;
		fin_cnt   = '0;
		grp       = '0;
		grp.fin_st = ST_OK;

		if (!stopped_q) begin
			if (cfg.string_mode && byte_in == 8'h00) begin
				stopped_n = 1'b1;
				stop_st_n = (pend_q != 2'd0) ? ST_TRUNC : ST_OK;
				pend_n    = 2'd0;
				acc_n     = '0;
			end else if (pend_q != 2'd0) begin
				acc_n  = {acc_q[CP_W-7:0], byte_in[5:0] & M_CONT[5:0]};
				pend_n = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					written_n          = written_q + count_t'(1);
					grp.mask[GRP_CP]   = 1'b1;
					grp.cp             = acc_n;
					grp.cp_cnt         = cnt_port(written_n);
					acc_n              = '0;
				end
			end else if (32'(written_q) >= lim) begin
				stopped_n = 1'b1;
				stop_st_n = ST_FULL;
				pend_n    = 2'd0;
				acc_n     = '0;
			end else if (byte_in < B_CONT_LO) begin
				written_n        = written_q + count_t'(1);
				grp.mask[GRP_CP] = 1'b1;
				grp.cp           = CP_W'(byte_in);
				grp.cp_cnt       = cnt_port(written_n);
			end else if (byte_in < B_LEAD2 || byte_in >= B_BAD_HI) begin
				stopped_n = 1'b1;
				stop_st_n = ST_BAD_LEAD;
				pend_n    = 2'd0;
				acc_n     = '0;
			end else if (byte_in < B_LEAD3) begin
				acc_n  = CP_W'(byte_in & M_LEAD2);
				pend_n = 2'd1;
			end else if (byte_in < B_LEAD4) begin
				acc_n  = CP_W'(byte_in & M_LEAD3);
				pend_n = 2'd2;
			end else begin
				acc_n  = CP_W'(byte_in & M_LEAD4);
				pend_n = 2'd3;
			end
		end

		if (last_in) begin
			// sequence still open at buffer end
			if (!stopped_n && pend_n != 2'd0) begin
				stopped_n = 1'b1;
				stop_st_n = ST_TRUNC;
			end
			grp.fin_st = stopped_n ? stop_st_n : ST_OK;
			fin_cnt    = written_n;
			if (cfg.string_mode) begin
				fin_cnt            = written_n + count_t'(1);
				grp.mask[GRP_TERM] = 1'b1;
			end
			grp.fin_cnt       = cnt_port(fin_cnt);
			grp.mask[GRP_END] = 1'b1;
			acc_n     = '0;
			pend_n    = 2'd0;
			written_n = '0;
			stopped_n = 1'b0;
			stop_st_n = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			pend_q    <= 2'd0;
			written_q <= '0;
			stopped_q <= 1'b0;
			stop_st_q <= ST_OK;
		end else if (fire) begin
			acc_q     <= acc_n;
			pend_q    <= pend_n;
			written_q <= written_n;
			stopped_q <= stopped_n;
			stop_st_q <= stop_st_n;
		end
	end

endmodule

[design/u2u_out.sv]
// result register and serialiser: holds the results of one byte, sends one a cycle while the output is not stalled
// uses u2u_pkg
module u2u_out import u2u_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  grp_t             grp,
	output logic             free,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [CP_W-1:0]  code_point,
	output logic             out_end,
	output logic [1:0]       status,
	output logic [CNT_W-1:0] written_count
);

	logic [2:0]       mask_s2;
	logic [CP_W-1:0]  cp_s2;
	logic [CNT_W-1:0] cp_cnt_s2;
	status_t          fin_st_s2;
	logic [CNT_W-1:0] fin_cnt_s2;

	logic       take;
	logic [2:0] mask_rest;

	assign out_valid = |mask_s2;
	assign take      = out_valid && !out_stall;
	// drop the lowest pending result
	assign mask_rest = mask_s2 & (mask_s2 - 3'd1);
	assign free      = (mask_s2 == 3'd0) || (take && mask_rest == 3'd0);

	always_comb begin
		if (mask_s2[GRP_CP]) begin
			code_point    = cp_s2;
			out_end       = 1'b0;
			status        = ST_OK;
			written_count = cp_cnt_s2;
		end else begin
			code_point    = '0;
			out_end       = !mask_s2[GRP_TERM];
			status        = fin_st_s2;
			written_count = fin_cnt_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= 3'd0;
		end else if (load) begin
			mask_s2 <= grp.mask;
		end else if (take) begin
			mask_s2 <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_s2      <= grp.cp;
			cp_cnt_s2  <= grp.cp_cnt;
			fin_st_s2  <= grp.fin_st;
			fin_cnt_s2 <= grp.fin_cnt;
		end
	end

endmodule

[design/utf8_to_ucs4_decoder.sv]
// top level of the utf-8 to ucs4 decoder: input register, configuration, decode, results
// uses u2u_pkg, u2u_decode, u2u_out

// Takes one UTF-8 byte per request, with in_last on the final byte of a buffer,
// and sends one result per request on the output: a code point for each complete
// sequence, then for the last byte an optional zero terminator (string mode) and
// an end result carrying the buffer status. A byte is taken every cycle as long
// as the output keeps up; a byte that yields at most one result does not hold the
// input, while a last byte yields up to three results and stalls the input until
// the single result register, which sends one result a cycle while the output is
// not stalled, is down to its last result. A request passes through the input
// register, then is decoded into the result register. Configuration is to be
// written by the user only while idle; the block itself does not enforce it.
module utf8_to_ucs4_decoder import u2u_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0]     cfg_data,
	// byte input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	// result output
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CP_W-1:0]      code_point,
	output logic                 out_end,
	output logic [1:0]           status,
	output logic [CNT_W-1:0]     written_count
);

	cfg_t       cfg_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic       free;
	logic       fire;
	grp_t       grp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_OUT_CAPACITY: cfg_q.out_capacity <= cfg_data;
				CFG_STRING_MODE:  cfg_q.string_mode  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// the byte in the input register decodes once the result register can take it
	assign fire     = valid_s1 && free;
	assign in_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload holds while stalled
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// sequence assembly, capacity check and stop handling
	u2u_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.cfg     (cfg_q),
		.grp     (grp)
	);

	// result register, one result per cycle towards the output while it does not stall
	u2u_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (fire),
		.grp           (grp),
		.free          (free),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code_point    (code_point),
		.out_end       (out_end),
		.status        (status),
		.written_count (written_count)
	);

endmodule

[dv/utf8_to_ucs4_decoder_tb.sv]
// testbench for the utf-8 to ucs4 decoder: directed and random byte buffers
// checked against a predictor of the decode; depends on u2u_pkg and the design top
`timescale 1ns / 100ps

module utf8_to_ucs4_decoder_tb;
	import u2u_pkg::*;

	// one result as it should leave the block
	typedef struct {
		logic [CP_W-1:0]  cp;
		logic             fin;
		status_t          st;
		logic [CNT_W-1:0] cnt;
	} ucs4_word_t;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 cfg_wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = CFG_OUT_CAPACITY;
	logic [CAP_W-1:0]     cfg_data      = '0;
	logic                 in_valid      = 1'b0;
	logic                 in_stall;
	logic [7:0]           in_byte       = 8'h00;
	logic                 in_last       = 1'b0;
	logic                 out_valid;
	logic                 out_stall     = 1'b0;
	logic [CP_W-1:0]      code_point;
	logic                 out_end;
	logic [1:0]           status;
	logic [CNT_W-1:0]     written_count;

	// decoded results still owed by the block, oldest first
	ucs4_word_t decoded_q[$];
	int         errors = 0;

	// predictor state, mirrors the block after reset
	logic [CP_W-1:0] acc       = '0;
	logic [1:0]      pend      = '0;
	count_t          n_written = '0;
	logic            halted    = 1'b0;
	status_t         halt_st   = ST_OK;
	logic [CAP_W-1:0] cap_reg  = '0;
	logic            str_mode  = 1'b0;

	// sender burst bookkeeping and the bytes of the buffer being sent
	int         tx_burst_left = 0;
	logic [7:0] frame_bytes[$];

	// receiver stall pattern
	int rx_mode      = 0;
	int rx_mode_left = 0;
	int rx_hold      = 0;

	utf8_to_ucs4_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.in_last       (in_last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code_point    (code_point),
		.out_end       (out_end),
		.status        (status),
		.written_count (written_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard limit on the whole run, far above the slowest legal run
	initial begin
		#2_000_000;
		$display("%0t: run did not complete in time", $time);
		$display("TEST FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	task automatic owe(input logic [CP_W-1:0] cp, input logic fin, input status_t st,
			input count_t cnt);
		ucs4_word_t w;
		w.cp  = cp;
		w.fin = fin;
		w.st  = st;
		w.cnt = cnt;
		decoded_q.push_back(w);
	endtask

	task automatic stop_decode(input status_t st);
		halted  = 1'b1;
		halt_st = st;
		pend    = '0;
		acc     = '0;
	endtask

	// how many code points may be written in this buffer
	function automatic logic [31:0] write_limit();
		logic [31:0] c;
		c = (cap_reg == '0) ? COUNT_MAX : 32'(cap_reg);
		if (c > COUNT_MAX)
			c = COUNT_MAX;
		// string mode keeps one slot back for the terminator
		if (str_mode)
			c = (c == 0) ? 32'd0 : c - 32'd1;
		return c;
	endfunction

	// advance the predictor by one accepted byte and queue what it causes
	task automatic decode_byte(input logic [7:0] b, input logic is_last);
		status_t st;
		count_t  cnt;
		if (!halted) begin
			if (str_mode && b == 8'h00) begin
				// zero byte ends the string; open sequence makes it truncated
				stop_decode(pend != 0 ? ST_TRUNC : ST_OK);
			end else if (pend != 0) begin
				// continuation: low six bits only, top bits never checked
				acc = {acc[CP_W-7:0], b[5:0]};
				pend--;
				if (pend == 0) begin
					n_written++;
					owe(acc, 1'b0, ST_OK, n_written);
					acc = '0;
				end
			end else if (32'(n_written) >= write_limit()) begin
				// capacity is looked at before the lead byte itself
				stop_decode(ST_FULL);
			end else if (b < B_CONT_LO) begin
				n_written++;
				owe({13'd0, b}, 1'b0, ST_OK, n_written);
			end else if (b < B_LEAD2 || b >= B_BAD_HI) begin
				stop_decode(ST_BAD_LEAD);
			end else if (b < B_LEAD3) begin
				acc  = CP_W'(b & M_LEAD2);
				pend = 2'd1;
			end else if (b < B_LEAD4) begin
				acc  = CP_W'(b & M_LEAD3);
				pend = 2'd2;
			end else begin
				acc  = CP_W'(b & M_LEAD4);
				pend = 2'd3;
			end
		end

		if (is_last) begin
			// buffer ends inside a sequence: partial value is dropped
			if (!halted && pend != 0)
				stop_decode(ST_TRUNC);
			st  = halted ? halt_st : ST_OK;
			cnt = n_written;
			if (str_mode) begin
				cnt++;
				owe('0, 1'b0, st, cnt);
			end
			owe('0, 1'b1, st, cnt);
			acc       = '0;
			pend      = '0;
			n_written = '0;
			halted    = 1'b0;
			halt_st   = ST_OK;
		end
	endtask

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------

	// signals are read at the edge, so they hold their pre-edge values
	always @(posedge clk) begin
		ucs4_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected result cp=%h end=%b st=%0d cnt=%0d", $time,
					code_point, out_end, status, written_count);
				errors++;
			end else begin
				want = decoded_q.pop_front();
				if (code_point !== want.cp || out_end !== want.fin ||
						status !== want.st || written_count !== want.cnt) begin
					$display("%0t: mismatch expected cp=%h end=%b st=%0d cnt=%0d",
						$time, want.cp, want.fin, want.st, want.cnt);
					$display("%0t:          actual   cp=%h end=%b st=%0d cnt=%0d",
						$time, code_point, out_end, status, written_count);
					errors++;
				end
			end
		end
	end

	// receiver stall: switches between no stall, light, bursty and heavy
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      <= $urandom_range(0, 3);
			rx_mode_left <= $urandom_range(40, 160);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		case (rx_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			2: begin
				if (rx_hold != 0) begin
					rx_hold   <= rx_hold - 1;
					out_stall <= 1'b1;
				end else if ($urandom_range(0, 9) == 0) begin
					rx_hold   <= $urandom_range(1, 7);
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
				end
			end
			default: begin
				out_stall <= ($urandom_range(0, 9) < 6);
			end
		endcase
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// one byte request; returns whether the block actually decoded it
	task automatic send_byte(input logic [7:0] b, input logic is_last, output bit counted);
		int gap;
		// new burst: maybe a gap first, sometimes none at all
		if (tx_burst_left == 0) begin
			tx_burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		tx_burst_left--;
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// bytes after a stop are skipped, except the last one
		counted = !(halted && !is_last);
		decode_byte(b, is_last);
	endtask

	// send frame_bytes as one buffer, in_last on the final byte
	task automatic send_frame(output int counted_n);
		bit c;
		counted_n = 0;
		for (int i = 0; i < frame_bytes.size(); i++) begin
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1, c);
			counted_n += c;
		end
	endtask

	// sender goes quiet until every owed result is out, then a little longer
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// both registers, written back to back while idle
	task automatic configure(input logic [CAP_W-1:0] cap, input logic sm);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_OUT_CAPACITY;
		cfg_data  <= cap;
		@(posedge clk);
		// upper data bits are don't care for the mode register
		cfg_index <= CFG_STRING_MODE;
		cfg_data  <= {15'($urandom), sm};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cap_reg  = cap;
		str_mode = sm;
	endtask

	// continuation byte, now and then with junk in the top two bits
	function automatic logic [7:0] cont_byte();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom_range(0, 255));
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] lead_byte(input int len);
		case (len)
			2:       return 8'($urandom_range(8'hC2, 8'hDF));
			3:       return 8'($urandom_range(8'hE0, 8'hEF));
			default: return 8'($urandom_range(8'hF0, 8'hF7));
		endcase
	endfunction

	// mostly well-formed characters, plus noise, zero bytes and cut sequences
	task automatic build_random_frame();
		int n_chars;
		int pick;
		int len;
		frame_bytes.delete();
		n_chars = $urandom_range(1, 7);
		for (int i = 0; i < n_chars; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = $urandom_range(1, 4);
				if (len == 1) begin
					frame_bytes.push_back(8'($urandom_range(1, 127)));
				end else begin
					frame_bytes.push_back(lead_byte(len));
					repeat (len - 1) frame_bytes.push_back(cont_byte());
				end
			end else if (pick < 75) begin
				frame_bytes.push_back(8'($urandom_range(1, 127)));
			end else if (pick < 85) begin
				frame_bytes.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				frame_bytes.push_back(8'h00);
			end else begin
				// sequence short of its continuations
				len = $urandom_range(2, 4);
				frame_bytes.push_back(lead_byte(len));
				repeat ($urandom_range(0, len - 2)) frame_bytes.push_back(cont_byte());
			end
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// one to four byte sequences at value extremes (lowest three-byte, highest four-byte), overlong allowed
	task automatic test_sequence_lengths();
		int n;
		configure(16'd0, 1'b0);
		frame_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80,
			8'hF7, 8'hBF, 8'hBF, 8'hBF};
		send_frame(n);
	endtask

	// lead bytes at both ends of the low bad range and the bottom of the high one; later bytes skipped
	task automatic test_invalid_lead();
		int n;
		frame_bytes = '{8'hC1, 8'h41};
		send_frame(n);
		frame_bytes = '{8'hF8};
		send_frame(n);
		frame_bytes = '{8'h80, 8'hFF};
		send_frame(n);
	endtask

	// buffer ends with continuation bytes still due
	task automatic test_truncation();
		int n;
		frame_bytes = '{8'hE2, 8'h82};
		send_frame(n);
	endtask

	// zero byte ends the string, cleanly and inside a sequence
	task automatic test_string_terminator();
		int n;
		configure(16'd4, 1'b1);
		frame_bytes = '{8'h41, 8'h00, 8'h42};
		send_frame(n);
		// sender holds off until the block has emptied
		wait_drained();
		frame_bytes = '{8'hC3, 8'h00};
		send_frame(n);
	endtask

	// output full, in plain mode and with only the terminator slot left
	task automatic test_capacity_limit();
		int n;
		configure(16'd2, 1'b0);
		frame_bytes = '{8'h41, 8'h42, 8'h43, 8'h44};
		send_frame(n);
		configure(16'd1, 1'b1);
		frame_bytes = '{8'h41};
		send_frame(n);
	endtask

	// sends buffers until about target bytes have gone in
	task automatic run_random_phase(input logic [CAP_W-1:0] cap, input logic sm,
			input int target);
		int total;
		int n;
		configure(cap, sm);
		total = 0;
		while (total < target) begin
			build_random_frame();
			send_frame(n);
			total += frame_bytes.size();
			if ($urandom_range(0, 14) == 0)
				wait_drained();
		end
	endtask

	// random buffers over a spread of settings, extremes included
	task automatic test_random_traffic();
		run_random_phase(16'd0, 1'b0, 30);
		run_random_phase(16'($urandom_range(1, 8)), 1'b0, 30);
		run_random_phase(16'd0, 1'b1, 30);
		run_random_phase(16'($urandom_range(1, 8)), 1'b1, 30);
		run_random_phase(16'hFFFF, 1'b0, 30);
		run_random_phase(16'hFFFF, 1'b1, 30);
		run_random_phase(16'd1, 1'b1, 30);
		run_random_phase(16'd1, 1'b0, 30);
	endtask

	// wait for the last results, then give the verdict
	task automatic finish_run();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (decoded_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (decoded_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, decoded_q.size());
			$display("TEST FAILED");
			$finish;
		end else begin
			repeat (20) @(posedge clk);
			if (errors == 0)
				$display("TEST PASSED");
			else
				$display("TEST FAILED");
			$finish;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sequence_lengths();
		test_invalid_lead();
		test_truncation();
		test_string_terminator();
		test_capacity_limit();
		test_random_traffic();
		finish_run();
	end

endmodule
